// ----- hw/rtl/rts_pkg.sv -----
// shared types, codes and helpers for the roundabout track sequencer
package rts_pkg;

    localparam int MAX_POINTS = 1023;

    localparam int CNT_W  = 10;
    localparam int DIST_W = 32;
    localparam int SAT_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_L_BEGIN = 4'd1,
        PH_L_IN    = 4'd2,
        PH_L_RUN   = 4'd3,
        PH_L_OUT   = 4'd4,
        PH_R_BEGIN = 4'd5,
        PH_R_IN    = 4'd6,
        PH_R_RUN   = 4'd7,
        PH_R_OUT   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        TRK_KEEP  = 2'd0,
        TRK_LEFT  = 2'd1,
        TRK_RIGHT = 2'd2
    } track_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LOST_THR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUND_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_FOUND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_CORNER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_DIST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INNER     = 3'd5;

    typedef struct packed {
        logic [CNT_W-1:0] lost_threshold;
        logic [CNT_W-1:0] found_threshold;
        logic [CNT_W-1:0] exit_found_threshold;
        logic [CNT_W-1:0] near_corner_threshold;
        logic [15:0]      abort_distance;
        logic [15:0]      min_inner_distance;
    } cfg_t;

    typedef struct packed {
        logic                     left_corner_found;
        logic                     right_corner_found;
        logic                     left_is_straight;
        logic                     right_is_straight;
        logic [CNT_W-1:0]         left_point_count;
        logic [CNT_W-1:0]         right_point_count;
        logic [CNT_W-1:0]         left_corner_index;
        logic [CNT_W-1:0]         right_corner_index;
        logic signed [DIST_W-1:0] travelled;
    } item_t;

    typedef struct packed {
        phase_t                   phase;
        logic [SAT_W-1:0]         left_lost_count;
        logic [SAT_W-1:0]         left_found_count;
        logic [SAT_W-1:0]         right_lost_count;
        logic [SAT_W-1:0]         right_found_count;
        logic signed [DIST_W-1:0] entry_distance;
    } seq_state_t;

    typedef struct packed {
        phase_t           mode;
        track_t           track_select;
        logic             element_start;
        logic             element_done;
        logic [CNT_W-1:0] left_count_out;
        logic [CNT_W-1:0] right_count_out;
    } result_t;

    function automatic logic [SAT_W-1:0] sat_inc(logic [SAT_W-1:0] c);
        logic [SAT_W-1:0] r;
        r = (c == {SAT_W{1'b1}}) ? c : c + 1'b1;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] clip_points(logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if ({6'b0, v} > 16'(MAX_POINTS))
        begin
            r = CNT_W'(MAX_POINTS);
        end
        return r;
    endfunction

    // exact distance since latch, one extra bit so it never wraps
    function automatic logic signed [DIST_W:0] dist_since(
        logic signed [DIST_W-1:0] d,
        logic signed [DIST_W-1:0] e
    );
        logic signed [DIST_W:0] r;
        r = $signed({d[DIST_W-1], d}) - $signed({e[DIST_W-1], e});
        return r;
    endfunction

    function automatic logic signed [DIST_W:0] dist_limit(logic [15:0] v);
        logic signed [DIST_W:0] r;
        r = $signed({17'b0, v});
        return r;
    endfunction

endpackage

// ----- hw/rtl/rts_step.sv -----
// next-state and result logic for one frame word
module rts_step
(
    input  rts_pkg::cfg_t       cfg,
    input  rts_pkg::item_t      item,
    input  rts_pkg::seq_state_t cur,
    output rts_pkg::seq_state_t nxt,
    output rts_pkg::result_t    res
);

    rts_pkg::phase_t                   ph;
    rts_pkg::track_t                   track;
    logic [rts_pkg::SAT_W-1:0]         ll;
    logic [rts_pkg::SAT_W-1:0]         lf;
    logic [rts_pkg::SAT_W-1:0]         rl;
    logic [rts_pkg::SAT_W-1:0]         rf;
    logic signed [rts_pkg::DIST_W-1:0] ent;
    logic [rts_pkg::CNT_W-1:0]         lcount;
    logic [rts_pkg::CNT_W-1:0]         rcount;
    logic [rts_pkg::CNT_W-1:0]         lidx;
    logic [rts_pkg::CNT_W-1:0]         ridx;
    logic                              start;
    logic                              done;
    logic                              lc;
    logic                              rc;

    always_comb
    begin
        ph     = cur.phase;
        ll     = cur.left_lost_count;
        lf     = cur.left_found_count;
        rl     = cur.right_lost_count;
        rf     = cur.right_found_count;
        ent    = cur.entry_distance;
        track  = rts_pkg::TRK_KEEP;
        start  = 1'b0;
        done   = 1'b0;
        lc     = item.left_corner_found;
        rc     = item.right_corner_found;
        lcount = rts_pkg::clip_points(item.left_point_count);
        rcount = rts_pkg::clip_points(item.right_point_count);
        lidx   = rts_pkg::clip_points(item.left_corner_index);
        ridx   = rts_pkg::clip_points(item.right_corner_index);

        // detection, only from idle
        if (ph == rts_pkg::PH_IDLE && lc && !rc && item.right_is_straight)
        begin
            ll = '0;
            lf = '0;
            start = 1'b1;
            ent = item.travelled;
            ph = rts_pkg::PH_L_BEGIN;
        end
        if (ph == rts_pkg::PH_IDLE && !lc && rc && item.left_is_straight)
        begin
            rl = '0;
            rf = '0;
            start = 1'b1;
            ent = item.travelled;
            ph = rts_pkg::PH_R_BEGIN;
        end

        // left roundabout; entered phases fall through in the same word
        if (ph == rts_pkg::PH_L_BEGIN)
        begin
            track = rts_pkg::TRK_RIGHT;
            if (lcount < cfg.lost_threshold)
                ll = rts_pkg::sat_inc(ll);
            if (lcount > cfg.found_threshold && ll > 8'd1)
            begin
                lf = rts_pkg::sat_inc(lf);
                if (lf > 8'd1)
                begin
                    ll = '0;
                    lf = '0;
                    ent = item.travelled;
                    ph = rts_pkg::PH_L_IN;
                end
            end
            if (ph != rts_pkg::PH_L_IN &&
                rts_pkg::dist_since(item.travelled, ent) >
                rts_pkg::dist_limit(cfg.abort_distance))
            begin
                ll = '0;
                lf = '0;
                done = 1'b1;
                ph = rts_pkg::PH_IDLE;
            end
        end
        if (ph == rts_pkg::PH_L_IN)
        begin
            track = rts_pkg::TRK_LEFT;
            if (rcount < cfg.lost_threshold)
                rl = rts_pkg::sat_inc(rl);
            if (rcount > cfg.found_threshold && rl > 8'd0)
            begin
                if (rts_pkg::dist_since(item.travelled, ent) >
                    rts_pkg::dist_limit(cfg.min_inner_distance))
                    rf = rts_pkg::sat_inc(rf);
                if (rf > 8'd0)
                begin
                    rl = '0;
                    rf = '0;
                    ph = rts_pkg::PH_L_RUN;
                end
            end
        end
        if (ph == rts_pkg::PH_L_RUN)
        begin
            track = rts_pkg::TRK_RIGHT;
            if (rc)
                rcount = ridx;
            if (rc && ridx < cfg.near_corner_threshold)
                ph = rts_pkg::PH_L_OUT;
        end
        if (ph == rts_pkg::PH_L_OUT)
        begin
            track = rts_pkg::TRK_LEFT;
            if (rc)
                rcount = ridx;
            if (rcount < cfg.lost_threshold)
                rl = rts_pkg::sat_inc(rl);
            if (rcount > cfg.exit_found_threshold && rl > 8'd0)
            begin
                if (rf > 8'd0)
                begin
                    rl = '0;
                    rf = '0;
                    done = 1'b1;
                    ph = rts_pkg::PH_IDLE;
                end
                else
                begin
                    rf = rts_pkg::sat_inc(rf);
                end
            end
        end

        // right roundabout
        if (ph == rts_pkg::PH_R_BEGIN)
        begin
            track = rts_pkg::TRK_LEFT;
            if (rcount < cfg.lost_threshold)
                rl = rts_pkg::sat_inc(rl);
            if (rcount > cfg.found_threshold && rl > 8'd1)
            begin
                rf = rts_pkg::sat_inc(rf);
                if (rf > 8'd1)
                begin
                    rl = '0;
                    rf = '0;
                    ent = item.travelled;
                    ph = rts_pkg::PH_R_IN;
                end
            end
            if (ph != rts_pkg::PH_R_IN &&
                rts_pkg::dist_since(item.travelled, ent) >
                rts_pkg::dist_limit(cfg.abort_distance))
            begin
                rl = '0;
                rf = '0;
                done = 1'b1;
                ph = rts_pkg::PH_IDLE;
            end
        end
        if (ph == rts_pkg::PH_R_IN)
        begin
            track = rts_pkg::TRK_RIGHT;
            if (lcount < cfg.lost_threshold)
                ll = rts_pkg::sat_inc(ll);
            if (lcount > cfg.found_threshold && ll > 8'd0)
            begin
                if (rts_pkg::dist_since(item.travelled, ent) >
                    rts_pkg::dist_limit(cfg.min_inner_distance))
                    lf = rts_pkg::sat_inc(lf);
                if (lf > 8'd0)
                begin
                    ll = '0;
                    lf = '0;
                    ph = rts_pkg::PH_R_RUN;
                end
            end
        end
        if (ph == rts_pkg::PH_R_RUN)
        begin
            track = rts_pkg::TRK_LEFT;
            if (lc)
                lcount = lidx;
            if (lc && lidx < cfg.near_corner_threshold)
                ph = rts_pkg::PH_R_OUT;
        end
        if (ph == rts_pkg::PH_R_OUT)
        begin
            track = rts_pkg::TRK_RIGHT;
            if (lc)
                lcount = lidx;
            if (lcount < cfg.lost_threshold)
                ll = rts_pkg::sat_inc(ll);
            if (lcount > cfg.exit_found_threshold && ll > 8'd0)
            begin
                if (lf > 8'd0)
                begin
                    ll = '0;
                    lf = '0;
                    done = 1'b1;
                    ph = rts_pkg::PH_IDLE;
                end
                else
                begin
                    lf = rts_pkg::sat_inc(lf);
                end
            end
        end

        nxt.phase             = ph;
        nxt.left_lost_count   = ll;
        nxt.left_found_count  = lf;
        nxt.right_lost_count  = rl;
        nxt.right_found_count = rf;
        nxt.entry_distance    = ent;

        res.mode            = ph;
        res.track_select    = track;
        res.element_start   = start;
        res.element_done    = done;
        res.left_count_out  = lcount;
        res.right_count_out = rcount;
    end

endmodule

// ----- hw/rtl/roundabout_track_sequencer_core.sv -----
// roundabout track sequencer top level: config, input and result registers, state
// a word moves from the input register to the result register as the result stage
// advances; throughput: one word per cycle while the result stage is not stalled; the
//   sequencer state update sits in one combinational step between the input register
//   and the result register; reset: phase idle, all counters and latched distance zero,
//   config registers at their default thresholds, both register stages empty
module roundabout_track_sequencer_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [rts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rts_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              left_corner_found,
    input  logic                              right_corner_found,
    input  logic                              left_is_straight,
    input  logic                              right_is_straight,
    input  logic [rts_pkg::CNT_W-1:0]         left_point_count,
    input  logic [rts_pkg::CNT_W-1:0]         right_point_count,
    input  logic [rts_pkg::CNT_W-1:0]         left_corner_index,
    input  logic [rts_pkg::CNT_W-1:0]         right_corner_index,
    input  logic signed [rts_pkg::DIST_W-1:0] travelled,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        mode,
    output logic [1:0]                        track_select,
    output logic                              element_start,
    output logic                              element_done,
    output logic [rts_pkg::CNT_W-1:0]         left_count_out,
    output logic [rts_pkg::CNT_W-1:0]         right_count_out
);

    rts_pkg::cfg_t       cfg_reg;
    rts_pkg::seq_state_t state_reg;
    rts_pkg::seq_state_t state_next;
    rts_pkg::item_t      item_reg;
    rts_pkg::result_t    res_reg;
    rts_pkg::result_t    res_next;
    logic                in_v_reg;
    logic                out_v_reg;
    logic                advance;
    logic                in_take;

    // result stage moves when empty or being taken
    assign advance  = !out_v_reg || !out_stall;
    assign in_stall = in_v_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_threshold        <= 10'd10;
            cfg_reg.found_threshold       <= 10'd40;
            cfg_reg.exit_found_threshold  <= 10'd50;
            cfg_reg.near_corner_threshold <= 10'd30;
            cfg_reg.abort_distance        <= 16'd100;
            cfg_reg.min_inner_distance    <= 16'd60;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rts_pkg::CFG_LOST_THR:
                    cfg_reg.lost_threshold <= cfg_data[rts_pkg::CNT_W-1:0];
                rts_pkg::CFG_FOUND_THR:
                    cfg_reg.found_threshold <= cfg_data[rts_pkg::CNT_W-1:0];
                rts_pkg::CFG_EXIT_FOUND:
                    cfg_reg.exit_found_threshold <= cfg_data[rts_pkg::CNT_W-1:0];
                rts_pkg::CFG_NEAR_CORNER:
                    cfg_reg.near_corner_threshold <= cfg_data[rts_pkg::CNT_W-1:0];
                rts_pkg::CFG_ABORT_DIST:
                    cfg_reg.abort_distance <= cfg_data;
                rts_pkg::CFG_MIN_INNER:
                    cfg_reg.min_inner_distance <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            state_reg <= '{phase: rts_pkg::PH_IDLE, default: '0};
        end
        else
        begin
            if (in_take)
                in_v_reg <= 1'b1;
            else if (advance)
                in_v_reg <= 1'b0;
            if (advance)
                out_v_reg <= in_v_reg;
            if (advance && in_v_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.left_corner_found  <= left_corner_found;
            item_reg.right_corner_found <= right_corner_found;
            item_reg.left_is_straight   <= left_is_straight;
            item_reg.right_is_straight  <= right_is_straight;
            item_reg.left_point_count   <= left_point_count;
            item_reg.right_point_count  <= right_point_count;
            item_reg.left_corner_index  <= left_corner_index;
            item_reg.right_corner_index <= right_corner_index;
            item_reg.travelled          <= travelled;
        end
        if (advance && in_v_reg)
            res_reg <= res_next;
    end

    rts_step u_step
    (
        .cfg  (cfg_reg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign out_valid       = out_v_reg;
    assign mode            = res_reg.mode;
    assign track_select    = res_reg.track_select;
    assign element_start   = res_reg.element_start;
    assign element_done    = res_reg.element_done;
    assign left_count_out  = res_reg.left_count_out;
    assign right_count_out = res_reg.right_count_out;

endmodule

// ----- dv/roundabout_track_sequencer_core_tb.sv -----
// self-checking testbench for the roundabout track sequencer core
`timescale 1ns / 1ps

module roundabout_track_sequencer_core_tb;

    // index with no register behind it, writes there must be ignored
    localparam logic [rts_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [rts_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [rts_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic                              left_corner_found;
    logic                              right_corner_found;
    logic                              left_is_straight;
    logic                              right_is_straight;
    logic [rts_pkg::CNT_W-1:0]         left_point_count;
    logic [rts_pkg::CNT_W-1:0]         right_point_count;
    logic [rts_pkg::CNT_W-1:0]         left_corner_index;
    logic [rts_pkg::CNT_W-1:0]         right_corner_index;
    logic signed [rts_pkg::DIST_W-1:0] travelled;
    logic                              out_valid;
    logic                              out_stall;
    logic [3:0]                        mode;
    logic [1:0]                        track_select;
    logic                              element_start;
    logic                              element_done;
    logic [rts_pkg::CNT_W-1:0]         left_count_out;
    logic [rts_pkg::CNT_W-1:0]         right_count_out;

    // predicted sequencer state and thresholds
    rts_pkg::phase_t                   seq_phase;
    logic [rts_pkg::SAT_W-1:0]         l_lost;
    logic [rts_pkg::SAT_W-1:0]         l_found;
    logic [rts_pkg::SAT_W-1:0]         r_lost;
    logic [rts_pkg::SAT_W-1:0]         r_found;
    logic signed [rts_pkg::DIST_W-1:0] latched_dist;
    logic [rts_pkg::CNT_W-1:0]         thr_lost;
    logic [rts_pkg::CNT_W-1:0]         thr_found;
    logic [rts_pkg::CNT_W-1:0]         thr_exit;
    logic [rts_pkg::CNT_W-1:0]         thr_near;
    logic [15:0]                       dist_abort;
    logic [15:0]                       dist_inner;

    rts_pkg::result_t pending_results[$];
    int               mismatch_count;
    int               gap_pct;
    int               hold_pct;
    bit               calm;
    int               odometer;

    roundabout_track_sequencer_core dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .left_corner_found  (left_corner_found),
        .right_corner_found (right_corner_found),
        .left_is_straight   (left_is_straight),
        .right_is_straight  (right_is_straight),
        .left_point_count   (left_point_count),
        .right_point_count  (right_point_count),
        .left_corner_index  (left_corner_index),
        .right_corner_index (right_corner_index),
        .travelled          (travelled),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .mode               (mode),
        .track_select       (track_select),
        .element_start      (element_start),
        .element_done       (element_done),
        .left_count_out     (left_count_out),
        .right_count_out    (right_count_out)
    );

    always #5 clk = ~clk;

    function automatic logic [rts_pkg::SAT_W-1:0] bump8(logic [rts_pkg::SAT_W-1:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    function automatic longint span_from_latch(logic signed [rts_pkg::DIST_W-1:0] d);
        return longint'($signed(d)) - longint'(latched_dist);
    endfunction

    // one frame through detection and the phase rules, updating the state
    function automatic rts_pkg::result_t advance_sequencer(rts_pkg::item_t f);
        rts_pkg::result_t          r;
        logic [rts_pkg::CNT_W-1:0] lcnt;
        logic [rts_pkg::CNT_W-1:0] rcnt;
        rts_pkg::track_t           trk;
        logic                      start;
        logic                      done;
        lcnt  = f.left_point_count;
        rcnt  = f.right_point_count;
        trk   = rts_pkg::TRK_KEEP;
        start = 1'b0;
        done  = 1'b0;

        if (seq_phase == rts_pkg::PH_IDLE && f.left_corner_found && !f.right_corner_found
            && f.right_is_straight)
        begin
            l_lost = '0;
            l_found = '0;
            start = 1'b1;
            latched_dist = f.travelled;
            seq_phase = rts_pkg::PH_L_BEGIN;
        end
        if (seq_phase == rts_pkg::PH_IDLE && !f.left_corner_found && f.right_corner_found
            && f.left_is_straight)
        begin
            r_lost = '0;
            r_found = '0;
            start = 1'b1;
            latched_dist = f.travelled;
            seq_phase = rts_pkg::PH_R_BEGIN;
        end

        if (seq_phase == rts_pkg::PH_L_BEGIN)
        begin
            trk = rts_pkg::TRK_RIGHT;
            if (lcnt < thr_lost)
                l_lost = bump8(l_lost);
            if (lcnt > thr_found && l_lost > 8'd1)
            begin
                l_found = bump8(l_found);
                if (l_found > 8'd1)
                begin
                    l_lost = '0;
                    l_found = '0;
                    latched_dist = f.travelled;
                    seq_phase = rts_pkg::PH_L_IN;
                end
            end
            if (seq_phase != rts_pkg::PH_L_IN &&
                span_from_latch(f.travelled) > longint'(dist_abort))
            begin
                l_lost = '0;
                l_found = '0;
                done = 1'b1;
                seq_phase = rts_pkg::PH_IDLE;
            end
        end
        if (seq_phase == rts_pkg::PH_L_IN)
        begin
            trk = rts_pkg::TRK_LEFT;
            if (rcnt < thr_lost)
                r_lost = bump8(r_lost);
            if (rcnt > thr_found && r_lost != 8'd0)
            begin
                if (span_from_latch(f.travelled) > longint'(dist_inner))
                    r_found = bump8(r_found);
                if (r_found != 8'd0)
                begin
                    r_lost = '0;
                    r_found = '0;
                    seq_phase = rts_pkg::PH_L_RUN;
                end
            end
        end
        if (seq_phase == rts_pkg::PH_L_RUN)
        begin
            trk = rts_pkg::TRK_RIGHT;
            if (f.right_corner_found)
                rcnt = f.right_corner_index;
            if (f.right_corner_found && f.right_corner_index < thr_near)
                seq_phase = rts_pkg::PH_L_OUT;
        end
        if (seq_phase == rts_pkg::PH_L_OUT)
        begin
            trk = rts_pkg::TRK_LEFT;
            if (f.right_corner_found)
                rcnt = f.right_corner_index;
            if (rcnt < thr_lost)
                r_lost = bump8(r_lost);
            if (rcnt > thr_exit && r_lost != 8'd0)
            begin
                if (r_found != 8'd0)
                begin
                    r_lost = '0;
                    r_found = '0;
                    done = 1'b1;
                    seq_phase = rts_pkg::PH_IDLE;
                end
                else
                begin
                    r_found = bump8(r_found);
                end
            end
        end

        if (seq_phase == rts_pkg::PH_R_BEGIN)
        begin
            trk = rts_pkg::TRK_LEFT;
            if (rcnt < thr_lost)
                r_lost = bump8(r_lost);
            if (rcnt > thr_found && r_lost > 8'd1)
            begin
                r_found = bump8(r_found);
                if (r_found > 8'd1)
                begin
                    r_lost = '0;
                    r_found = '0;
                    latched_dist = f.travelled;
                    seq_phase = rts_pkg::PH_R_IN;
                end
            end
            if (seq_phase != rts_pkg::PH_R_IN &&
                span_from_latch(f.travelled) > longint'(dist_abort))
            begin
                r_lost = '0;
                r_found = '0;
                done = 1'b1;
                seq_phase = rts_pkg::PH_IDLE;
            end
        end
        if (seq_phase == rts_pkg::PH_R_IN)
        begin
            trk = rts_pkg::TRK_RIGHT;
            if (lcnt < thr_lost)
                l_lost = bump8(l_lost);
            if (lcnt > thr_found && l_lost != 8'd0)
            begin
                if (span_from_latch(f.travelled) > longint'(dist_inner))
                    l_found = bump8(l_found);
                if (l_found != 8'd0)
                begin
                    l_lost = '0;
                    l_found = '0;
                    seq_phase = rts_pkg::PH_R_RUN;
                end
            end
        end
        if (seq_phase == rts_pkg::PH_R_RUN)
        begin
            trk = rts_pkg::TRK_LEFT;
            if (f.left_corner_found)
                lcnt = f.left_corner_index;
            if (f.left_corner_found && f.left_corner_index < thr_near)
                seq_phase = rts_pkg::PH_R_OUT;
        end
        if (seq_phase == rts_pkg::PH_R_OUT)
        begin
            trk = rts_pkg::TRK_RIGHT;
            if (f.left_corner_found)
                lcnt = f.left_corner_index;
            if (lcnt < thr_lost)
                l_lost = bump8(l_lost);
            if (lcnt > thr_exit && l_lost != 8'd0)
            begin
                if (l_found != 8'd0)
                begin
                    l_lost = '0;
                    l_found = '0;
                    done = 1'b1;
                    seq_phase = rts_pkg::PH_IDLE;
                end
                else
                begin
                    l_found = bump8(l_found);
                end
            end
        end

        r.mode            = seq_phase;
        r.track_select    = trk;
        r.element_start   = start;
        r.element_done    = done;
        r.left_count_out  = lcnt;
        r.right_count_out = rcnt;
        return r;
    endfunction

    function automatic logic [rts_pkg::CNT_W-1:0] count_under(
        logic [rts_pkg::CNT_W-1:0] thr
    );
        return (thr == 0) ? 10'd0 : 10'($urandom_range(thr - 1, 0));
    endfunction

    function automatic logic [rts_pkg::CNT_W-1:0] count_over(
        logic [rts_pkg::CNT_W-1:0] thr
    );
        return (thr == 10'd1023) ? 10'd1023 : 10'($urandom_range(1023, thr + 1));
    endfunction

    function automatic rts_pkg::item_t noise_frame();
        rts_pkg::item_t f;
        f.left_corner_found  = 1'($urandom_range(1, 0));
        f.right_corner_found = 1'($urandom_range(1, 0));
        f.left_is_straight   = 1'($urandom_range(1, 0));
        f.right_is_straight  = 1'($urandom_range(1, 0));
        f.left_point_count   = 10'($urandom_range(1023, 0));
        f.right_point_count  = 10'($urandom_range(1023, 0));
        f.left_corner_index  = 10'($urandom_range(1023, 0));
        f.right_corner_index = 10'($urandom_range(1023, 0));
        f.travelled          = $urandom;
        return f;
    endfunction

    // frame that pushes the current roundabout one step further, now and then noise
    function automatic rts_pkg::item_t next_frame();
        rts_pkg::item_t            f;
        bit                        right_side;
        logic                      a_c, b_c, a_s, b_s;
        logic [rts_pkg::CNT_W-1:0] a_n, b_n, a_i, b_i;
        logic [rts_pkg::SAT_W-1:0] a_lost, b_lost;
        f = noise_frame();
        if ($urandom_range(9, 0) == 0)
            odometer += int'($urandom_range(80000, 0));
        else
            odometer += int'($urandom_range(25, 0));
        if ($urandom_range(99, 0) < 12)
        begin
            if ($urandom_range(1, 0) == 0)
                f.travelled = odometer;
            return f;
        end
        f.travelled = odometer;

        if (seq_phase == rts_pkg::PH_IDLE)
            right_side = 1'($urandom_range(1, 0));
        else
            right_side = (seq_phase >= rts_pkg::PH_R_BEGIN);
        if (right_side)
        begin
            a_c = f.right_corner_found;  b_c = f.left_corner_found;
            a_s = f.right_is_straight;   b_s = f.left_is_straight;
            a_n = f.right_point_count;   b_n = f.left_point_count;
            a_i = f.right_corner_index;  b_i = f.left_corner_index;
            a_lost = r_lost;             b_lost = l_lost;
        end
        else
        begin
            a_c = f.left_corner_found;   b_c = f.right_corner_found;
            a_s = f.left_is_straight;    b_s = f.right_is_straight;
            a_n = f.left_point_count;    b_n = f.right_point_count;
            a_i = f.left_corner_index;   b_i = f.right_corner_index;
            a_lost = l_lost;             b_lost = r_lost;
        end

        // a is the roundabout side, b the far line
        case (seq_phase)
            rts_pkg::PH_IDLE:
            begin
                a_c = 1'b1;
                b_c = 1'b0;
                b_s = 1'b1;
            end
            rts_pkg::PH_L_BEGIN, rts_pkg::PH_R_BEGIN:
                a_n = (a_lost > 8'd1) ? count_over(thr_found) : count_under(thr_lost);
            rts_pkg::PH_L_IN, rts_pkg::PH_R_IN:
                b_n = (b_lost != 8'd0) ? count_over(thr_found) : count_under(thr_lost);
            rts_pkg::PH_L_RUN, rts_pkg::PH_R_RUN:
            begin
                b_c = ($urandom_range(3, 0) != 0);
                b_i = count_under(thr_near);
            end
            default:
            begin
                b_n = (b_lost != 8'd0) ? count_over(thr_exit) : count_under(thr_lost);
                if (b_c)
                    b_i = b_n;
            end
        endcase

        if (right_side)
        begin
            f.right_corner_found = a_c;  f.left_corner_found = b_c;
            f.right_is_straight  = a_s;  f.left_is_straight  = b_s;
            f.right_point_count  = a_n;  f.left_point_count  = b_n;
            f.right_corner_index = a_i;  f.left_corner_index = b_i;
        end
        else
        begin
            f.left_corner_found  = a_c;  f.right_corner_found = b_c;
            f.left_is_straight   = a_s;  f.right_is_straight  = b_s;
            f.left_point_count   = a_n;  f.right_point_count  = b_n;
            f.left_corner_index  = a_i;  f.right_corner_index = b_i;
        end
        return f;
    endfunction

    task automatic send_frame(input rts_pkg::item_t f);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99, 0) < gap_pct)
            gap = int'($urandom_range(12, 1));
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        left_corner_found  <= f.left_corner_found;
        right_corner_found <= f.right_corner_found;
        left_is_straight   <= f.left_is_straight;
        right_is_straight  <= f.right_is_straight;
        left_point_count   <= f.left_point_count;
        right_point_count  <= f.right_point_count;
        left_corner_index  <= f.left_corner_index;
        right_corner_index <= f.right_corner_index;
        travelled          <= f.travelled;
        in_valid           <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(advance_sequencer(f));
    endtask

    task automatic send_features(input bit lc, input bit rc, input bit ls, input bit rs,
                                 input int ln, input int rn, input int li, input int ri,
                                 input logic signed [rts_pkg::DIST_W-1:0] d);
        rts_pkg::item_t f;
        f.left_corner_found  = lc;
        f.right_corner_found = rc;
        f.left_is_straight   = ls;
        f.right_is_straight  = rs;
        f.left_point_count   = ln[rts_pkg::CNT_W-1:0];
        f.right_point_count  = rn[rts_pkg::CNT_W-1:0];
        f.left_corner_index  = li[rts_pkg::CNT_W-1:0];
        f.right_corner_index = ri[rts_pkg::CNT_W-1:0];
        f.travelled          = d;
        send_frame(f);
    endtask

    task automatic run_frames(input int n);
        repeat (n)
            send_frame(next_frame());
    endtask

    task automatic drain_sequencer();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rts_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            rts_pkg::CFG_LOST_THR:    thr_lost   = value[rts_pkg::CNT_W-1:0];
            rts_pkg::CFG_FOUND_THR:   thr_found  = value[rts_pkg::CNT_W-1:0];
            rts_pkg::CFG_EXIT_FOUND:  thr_exit   = value[rts_pkg::CNT_W-1:0];
            rts_pkg::CFG_NEAR_CORNER: thr_near   = value[rts_pkg::CNT_W-1:0];
            rts_pkg::CFG_ABORT_DIST:  dist_abort = value[15:0];
            rts_pkg::CFG_MIN_INNER:   dist_inner = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned lost, input int unsigned found,
                                  input int unsigned leave, input int unsigned near,
                                  input int unsigned abort_d, input int unsigned inner_d);
        drain_sequencer();
        write_reg(rts_pkg::CFG_LOST_THR, lost);
        write_reg(rts_pkg::CFG_FOUND_THR, found);
        write_reg(rts_pkg::CFG_EXIT_FOUND, leave);
        write_reg(rts_pkg::CFG_NEAR_CORNER, near);
        write_reg(rts_pkg::CFG_ABORT_DIST, abort_d);
        write_reg(rts_pkg::CFG_MIN_INNER, inner_d);
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t %s expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        rts_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t result word with none expected, actual mode %0d", $time, mode);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("mode", want.mode, mode);
                compare_field("track_select", want.track_select, track_select);
                compare_field("element_start", want.element_start, element_start);
                compare_field("element_done", want.element_done, element_done);
                compare_field("left_count_out", want.left_count_out, left_count_out);
                compare_field("right_count_out", want.right_count_out, right_count_out);
            end
        end
    end

    initial
    begin : result_stall
        int burst;
        burst = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst == 0 && !calm && $urandom_range(99, 0) < hold_pct)
                burst = int'($urandom_range(12, 1));
            if (burst != 0 && !calm)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // extremes, every phase step, corner replacement and the distance edge cases
    task automatic test_directed_cases();
        gap_pct  = 30;
        hold_pct = 30;
        send_features(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_features(1, 1, 1, 1, 1023, 1023, 1023, 1023, 32'sh7FFF_FFFF);
        send_features(0, 0, 1, 1, 500, 500, 500, 500, 5);
        send_features(1, 0, 1, 0, 500, 500, 500, 500, 5);
        // left roundabout walked through every phase
        send_features(1, 0, 0, 1, 100, 100, 0, 0, 0);
        send_features(0, 0, 0, 0, 5, 100, 0, 0, 10);
        send_features(0, 0, 0, 0, 5, 100, 0, 0, 20);
        send_features(0, 0, 0, 0, 100, 100, 0, 0, 30);
        send_features(0, 0, 0, 0, 100, 500, 0, 0, 40);
        send_features(0, 0, 0, 0, 100, 3, 0, 0, 50);
        send_features(0, 0, 0, 0, 100, 200, 0, 0, 70);
        // corner index larger than the point count
        send_features(0, 1, 0, 0, 100, 200, 0, 900, 200);
        send_features(0, 1, 0, 0, 100, 800, 0, 5, 210);
        send_features(0, 0, 0, 0, 100, 1023, 0, 0, 220);
        send_features(0, 0, 0, 0, 100, 1023, 0, 0, 230);
        // right begin, then abort across the full signed distance range
        send_features(0, 1, 1, 0, 300, 300, 0, 0, 32'sh8000_0000);
        send_features(0, 0, 0, 0, 300, 300, 0, 0, 32'sh7FFF_FFFF);
        // right begin with a lost line in the same frame, distance going back
        send_features(0, 1, 1, 0, 300, 0, 0, 0, 32'sh7FFF_FFFF);
        send_features(0, 0, 0, 0, 300, 0, 0, 0, 32'sh8000_0000);
        send_features(0, 0, 0, 0, 300, 1000, 0, 0, 32'sh8000_0000);
        send_features(0, 0, 0, 0, 1023, 1000, 0, 0, 32'sh8000_0030);
        send_features(0, 0, 0, 0, 0, 1000, 0, 0, 32'sh8000_0040);
        // inner line accepted, run and out entered in the same frame
        send_features(1, 0, 0, 0, 1000, 1000, 2, 0, 0);
        send_features(1, 0, 0, 0, 0, 1000, 600, 0, 10);
        send_features(1, 0, 0, 0, 0, 1000, 700, 0, 20);
    endtask

    // lost counters held in begin long enough to saturate
    task automatic test_lost_saturation();
        rts_pkg::item_t f;
        int             n;
        gap_pct  = 0;
        hold_pct = 0;
        for (int side = 0; side < 2; side++)
        begin
            f = noise_frame();
            f.left_corner_found  = (side == 0);
            f.right_corner_found = (side == 1);
            if (side == 0)
                f.right_is_straight = 1'b1;
            else
                f.left_is_straight = 1'b1;
            f.travelled = odometer;
            send_frame(f);
            repeat (265)
            begin
                f = noise_frame();
                f.travelled = odometer;
                if (side == 0)
                    f.left_point_count = count_under(thr_lost);
                else
                    f.right_point_count = count_under(thr_lost);
                send_frame(f);
            end
            gap_pct  = 25;
            hold_pct = 25;
            n = 0;
            while (seq_phase != rts_pkg::PH_IDLE && n < 300)
            begin
                send_frame(next_frame());
                n++;
            end
        end
    endtask

    task automatic test_register_extremes();
        gap_pct  = 20;
        hold_pct = 10;
        apply_settings(0, 0, 0, 0, 0, 0);
        run_frames(120);
        gap_pct  = 5;
        hold_pct = 35;
        apply_settings(1023, 1023, 1023, 1023, 65535, 65535);
        run_frames(120);
        // upper data bits set on the narrow registers
        gap_pct  = 15;
        hold_pct = 15;
        apply_settings(16'hFC05, 16'hFFFF, 16'h8000, 16'h7C20, 16'h8001, 0);
        run_frames(120);
        apply_settings(10, 40, 50, 30, 100, 60);
        write_reg(CFG_SPARE, $urandom_range(65535, 0));
        run_frames(120);
    endtask

    task automatic test_random_traffic();
        repeat (3)
        begin
            gap_pct  = int'($urandom_range(40, 0));
            hold_pct = int'($urandom_range(40, 0));
            apply_settings($urandom_range(60, 1), $urandom_range(200, 0),
                           $urandom_range(200, 0), $urandom_range(100, 1),
                           $urandom_range(2000, 20), $urandom_range(500, 0));
            run_frames(180);
        end
        gap_pct  = 20;
        hold_pct = 20;
        apply_settings(10, 40, 50, 30, 100, 60);
        run_frames(100);
        calm = 1'b1;
        run_frames(150);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = rts_pkg::CFG_LOST_THR;
        cfg_data           = '0;
        in_valid           = 1'b0;
        left_corner_found  = 1'b0;
        right_corner_found = 1'b0;
        left_is_straight   = 1'b0;
        right_is_straight  = 1'b0;
        left_point_count   = '0;
        right_point_count  = '0;
        left_corner_index  = '0;
        right_corner_index = '0;
        travelled          = '0;
        seq_phase          = rts_pkg::PH_IDLE;
        l_lost             = '0;
        l_found            = '0;
        r_lost             = '0;
        r_found            = '0;
        latched_dist       = '0;
        thr_lost           = 10'd10;
        thr_found          = 10'd40;
        thr_exit           = 10'd50;
        thr_near           = 10'd30;
        dist_abort         = 16'd100;
        dist_inner         = 16'd60;
        mismatch_count     = 0;
        gap_pct            = 0;
        hold_pct           = 0;
        calm               = 1'b0;
        odometer           = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_lost_saturation();
        test_register_extremes();
        test_random_traffic();

        drain_sequencer();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[roundabout_track_sequencer_core] OK");
        else
            $display("[roundabout_track_sequencer_core] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[roundabout_track_sequencer_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rts_pkg.sv
hw/rtl/rts_step.sv
hw/rtl/roundabout_track_sequencer_core.sv
dv/roundabout_track_sequencer_core_tb.sv
